// ----- hw/rtl/mbc1_pkg.sv -----
// -----------------------------------------------------------------------------
// mbc1_pkg
// Shared constants, codes and types of the MBC1 cartridge bank controller.
// -----------------------------------------------------------------------------
package mbc1_pkg;

   // RAM geometry
   localparam int RAM_BANK_BYTES = 8192;
   localparam int RAM_BANK_COUNT = 4;
   localparam int ROM_BANK_BITS  = 5;

   localparam int BANK_OFF_W  = $clog2(RAM_BANK_BYTES);
   localparam int BANK_SEL_W  = 2;
   localparam int STORE_DEPTH = RAM_BANK_BYTES * RAM_BANK_COUNT;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Field widths
   localparam int ADDR_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int ROM_ADDR_W = 20;
   localparam int TARGET_W   = 2;
   localparam int CART_W     = 8;
   localparam int SIZE_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CART_TYPE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_SIZE  = 1'd1;

   // Response target codes
   localparam logic [TARGET_W-1:0] TGT_ROM   = 2'd0;
   localparam logic [TARGET_W-1:0] TGT_RAM   = 2'd1;
   localparam logic [TARGET_W-1:0] TGT_OPEN  = 2'd2;
   localparam logic [TARGET_W-1:0] TGT_WRITE = 2'd3;

   // Address regions, bus_address[15:13]
   localparam logic [2:0] REGION_RAM_EN   = 3'd0;  // 0x0000
   localparam logic [2:0] REGION_ROM_BANK = 3'd1;  // 0x2000
   localparam logic [2:0] REGION_RAM_BANK = 3'd2;  // 0x4000
   localparam logic [2:0] REGION_MODE     = 3'd3;  // 0x6000
   localparam logic [2:0] REGION_EXT_RAM  = 3'd5;  // 0xA000

   localparam logic [ADDR_W-1:0] ROM_WINDOW_BASE = 16'h4000;
   localparam logic [3:0]        RAM_EN_KEY      = 4'hA;
   localparam logic [BYTE_W-1:0] OPEN_BUS_BYTE   = 8'hFF;
   localparam logic [CART_W-1:0] CART_SAVE_RAM   = 8'd3;

   // Store access and response metadata from the register block
   typedef struct packed {
      logic                   ram_en;
      logic                   ram_we;
      logic [STORE_AW-1:0]    ram_addr;
      logic [BYTE_W-1:0]      ram_wdata;
      logic [TARGET_W-1:0]    target;
      logic [ROM_ADDR_W-1:0]  rom_address;
      logic [BYTE_W-1:0]      fixed_byte;
      logic                   save_pending;
   } mbc1_access_type;

endpackage

// ----- hw/rtl/mbc1_ram.sv -----
// -----------------------------------------------------------------------------
// mbc1_ram
// Generic single-port synchronous RAM with registered read.
// -----------------------------------------------------------------------------
module mbc1_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/mbc1_regs.sv -----
// -----------------------------------------------------------------------------
// mbc1_regs
// Configuration and bank registers; decodes one bus request into a store
// access and response metadata.
// -----------------------------------------------------------------------------
module mbc1_regs
   import mbc1_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  accept,
   input  logic                  mode,
   input  logic [ADDR_W-1:0]     bus_address,
   input  logic [BYTE_W-1:0]     write_byte,
   output mbc1_access_type       access
);

   logic [CART_W-1:0]        cart_type_ff, cart_type_in;
   logic [SIZE_W-1:0]        ram_size_ff, ram_size_in;
   logic                     ram_enable_ff, ram_enable_in;
   logic [ROM_BANK_BITS-1:0] rom_bank_ff, rom_bank_in;
   logic [BANK_SEL_W-1:0]    ram_bank_num_ff, ram_bank_num_in;
   logic                     bank_mode_ff, bank_mode_in;
   logic [BANK_SEL_W-1:0]    active_bank_ff, active_bank_in;
   logic                     save_flag_ff, save_flag_in;

   logic                     banking;
   logic [2:0]               region;
   logic [SIZE_W-1:0]        bank_count;
   logic                     present;
   logic                     ram_ok;
   logic [BANK_SEL_W+BANK_OFF_W-1:0] store_sum;
   logic [ROM_ADDR_W-1:0]    rom_switch;
   logic                     ram_store_wr;

   always_comb begin
      banking = cart_type_ff inside {[8'd1:8'd3]};
      region  = bus_address[15:13];

      if (ram_size_ff == 3'd2) begin
         bank_count = 3'd1;
      end else if (ram_size_ff inside {[3'd3:3'd5]}) begin
         bank_count = 3'd4;
      end else begin
         bank_count = 3'd0;
      end
      present = ({1'b0, active_bank_ff} < bank_count) &&
                ({1'b0, active_bank_ff} < SIZE_W'(RAM_BANK_COUNT));
      ram_ok  = ram_enable_ff && present;

      store_sum  = {active_bank_ff, bus_address[BANK_OFF_W-1:0]};
      rom_switch = {1'b0, rom_bank_ff, 14'd0} +
                   ROM_ADDR_W'(bus_address - ROM_WINDOW_BASE);

      ram_store_wr = mode && banking && (region == REGION_EXT_RAM) && ram_ok;
   end

   // next state
   always_comb begin
      cart_type_in    = cart_type_ff;
      ram_size_in     = ram_size_ff;
      ram_enable_in   = ram_enable_ff;
      rom_bank_in     = rom_bank_ff;
      ram_bank_num_in = ram_bank_num_ff;
      bank_mode_in    = bank_mode_ff;
      active_bank_in  = active_bank_ff;
      save_flag_in    = save_flag_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_CART_TYPE: cart_type_in = csr_write_data;
            CSR_RAM_SIZE:  ram_size_in  = csr_write_data[SIZE_W-1:0];
            default: ;
         endcase
      end

      if (accept && mode && banking) begin
         case (region)
            REGION_RAM_EN: begin
               ram_enable_in = (write_byte[3:0] == RAM_EN_KEY);
            end
            REGION_ROM_BANK: begin
               rom_bank_in = (write_byte[ROM_BANK_BITS-1:0] == '0) ?
                             ROM_BANK_BITS'(1) : write_byte[ROM_BANK_BITS-1:0];
            end
            REGION_RAM_BANK: begin
               ram_bank_num_in = write_byte[BANK_SEL_W-1:0];
               if (bank_mode_ff) begin
                  active_bank_in = write_byte[BANK_SEL_W-1:0];
               end
            end
            REGION_MODE: begin
               bank_mode_in = write_byte[0];
               if (write_byte[0]) begin
                  active_bank_in = ram_bank_num_ff;
               end
            end
            default: ;
         endcase
         if (ram_store_wr && (cart_type_ff == CART_SAVE_RAM)) begin
            save_flag_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff    <= '0;
         ram_size_ff     <= '0;
         ram_enable_ff   <= 1'b0;
         rom_bank_ff     <= ROM_BANK_BITS'(1);
         ram_bank_num_ff <= '0;
         bank_mode_ff    <= 1'b0;
         active_bank_ff  <= '0;
         save_flag_ff    <= 1'b0;
      end else begin
         cart_type_ff    <= cart_type_in;
         ram_size_ff     <= ram_size_in;
         ram_enable_ff   <= ram_enable_in;
         rom_bank_ff     <= rom_bank_in;
         ram_bank_num_ff <= ram_bank_num_in;
         bank_mode_ff    <= bank_mode_in;
         active_bank_ff  <= active_bank_in;
         save_flag_ff    <= save_flag_in;
      end
   end

   // response decode
   always_comb begin
      access              = '0;
      access.ram_addr     = store_sum[STORE_AW-1:0];
      access.ram_wdata    = write_byte;
      access.save_pending = save_flag_in;

      if (mode) begin
         access.target = TGT_WRITE;
         access.ram_en = accept && ram_store_wr;
         access.ram_we = 1'b1;
      end else if (!banking || (bus_address[15:14] == 2'd0)) begin
         access.target      = TGT_ROM;
         access.rom_address = ROM_ADDR_W'(bus_address);
      end else if (region == REGION_EXT_RAM) begin
         if (ram_ok) begin
            access.target = TGT_RAM;
            access.ram_en = accept;
         end else begin
            access.target     = TGT_OPEN;
            access.fixed_byte = OPEN_BUS_BYTE;
         end
      end else begin
         access.target      = TGT_ROM;
         access.rom_address = rom_switch;
      end
   end

   // only reset clears the save flag
   a_save_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(save_flag_ff))
      else $error("save flag cleared without reset");

   a_rom_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rom_bank_ff != '0)
      else $error("ROM bank register holds zero");

   // in mode 1 the active RAM bank tracks the bank number register
   a_active_bank: assert property (@(posedge clock) disable iff (reset)
      bank_mode_ff |-> (active_bank_ff == ram_bank_num_ff))
      else $error("active RAM bank out of step with bank number");

endmodule

// ----- hw/rtl/mbc1_cart_bank_controller.sv -----
// -----------------------------------------------------------------------------
// mbc1_cart_bank_controller
// MBC1-style cartridge bank controller: bank registers, ROM address
// translation and up to four 8 KiB banks of on-cart RAM.
// -----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  mode, bus_address, write_byte
//  rsp_      out        rsp_valid/rsp_stall  target, rom_address, read_byte,
//                                             save_pending
//  csr_      in         csr_write_enable     csr_index, csr_write_data
//
//  One request per cycle while req_stall is low. The RAM read and the
//  metadata enter the read stage when a request is taken; the read stage
//  passes them on to the output register once that register is free.
//  The single RAM port sees at most one access per request, so reads and
//  writes never collide.
//  After reset a clearing pass zeroes all STORE_DEPTH (32768) RAM bytes,
//  during which req_stall is held high. CSR writes are taken throughout.
//  rsp_stall back-pressures through the read stage to req_stall.
// -----------------------------------------------------------------------------
module mbc1_cart_bank_controller
   import mbc1_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [ADDR_W-1:0]     req_bus_address,
   input  logic [BYTE_W-1:0]     req_write_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TARGET_W-1:0]   rsp_target,
   output logic [ROM_ADDR_W-1:0] rsp_rom_address,
   output logic [BYTE_W-1:0]     rsp_read_byte,
   output logic                  rsp_save_pending
);

   mbc1_access_type access;

   logic req_accept;
   logic out_free;
   logic s1_move;
   logic s1_free;

   // clearing pass
   logic                clear_ff, clear_in;
   logic [STORE_AW-1:0] clear_addr_ff, clear_addr_in;

   // read stage: request metadata while RAM data is fetched
   logic                  s1_valid_ff, s1_valid_in;
   logic [TARGET_W-1:0]   s1_target_ff;
   logic [ROM_ADDR_W-1:0] s1_rom_address_ff;
   logic [BYTE_W-1:0]     s1_byte_ff;
   logic                  s1_save_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TARGET_W-1:0]   rsp_target_ff;
   logic [ROM_ADDR_W-1:0] rsp_rom_address_ff;
   logic [BYTE_W-1:0]     rsp_read_byte_ff;
   logic                  rsp_save_ff;

   // RAM port
   logic                  ram_en;
   logic                  ram_we;
   logic [STORE_AW-1:0]   ram_addr;
   logic [BYTE_W-1:0]     ram_wdata;
   logic [BYTE_W-1:0]     ram_rdata;

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_free;
   assign s1_free    = !s1_valid_ff || s1_move;
   assign req_stall  = clear_ff || !s1_free;
   assign req_accept = req_valid && !req_stall;

   mbc1_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (req_accept),
      .mode             (req_mode),
      .bus_address      (req_bus_address),
      .write_byte       (req_write_byte),
      .access           (access)
   );

   // RAM port: clearing pass owns it until done
   always_comb begin
      if (clear_ff) begin
         ram_en    = 1'b1;
         ram_we    = 1'b1;
         ram_addr  = clear_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_en    = access.ram_en;
         ram_we    = access.ram_we;
         ram_addr  = access.ram_addr;
         ram_wdata = access.ram_wdata;
      end
   end

   mbc1_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_target_ff      <= access.target;
         s1_rom_address_ff <= access.rom_address;
         s1_byte_ff        <= access.fixed_byte;
         s1_save_ff        <= access.save_pending;
      end
      if (s1_move) begin
         rsp_target_ff      <= s1_target_ff;
         rsp_rom_address_ff <= s1_rom_address_ff;
         rsp_read_byte_ff   <= (s1_target_ff == TGT_RAM) ? ram_rdata : s1_byte_ff;
         rsp_save_ff        <= s1_save_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target       = rsp_target_ff;
   assign rsp_rom_address  = rsp_rom_address_ff;
   assign rsp_read_byte    = rsp_read_byte_ff;
   assign rsp_save_pending = rsp_save_ff;

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_accept)
      else $error("request accepted during RAM clearing pass");

   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request lost before read stage");

   a_clear_owns_port: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (ram_we && ram_wdata == '0))
      else $error("RAM port not held by clearing pass");

endmodule
